FILE: src/rpu_pkg.sv
// Shared constants, register codes and item types of the RMSProp update block.
package rpu_pkg;

   localparam int FracBits          = 24;
   localparam int CacheDepthDefault = 4096;

   localparam int IdxW   = 12;
   localparam int ValW   = 32;
   localparam int IterW  = 20;
   localparam int RateW  = 24;
   localparam int RhoW   = 25;
   localparam int G2W    = 2 * ValW - 1 - FracBits;
   localparam int DmulW  = RateW + IterW;
   localparam int FifoDepth = 4;
   localparam int CsrAddrW  = 4;
   localparam int CsrDataW  = 32;

   localparam logic [RhoW-1:0]  OneFix      = RhoW'(1) << FracBits;
   localparam logic [RateW-1:0] BaseRateRst = 24'd16777;
   localparam logic [RateW-1:0] DecayRst    = 24'd0;
   localparam logic [RateW-1:0] EpsRst      = 24'd2;
   localparam logic [RhoW-1:0]  RhoRst      = 25'd15099494;

   localparam logic [ValW-1:0] MaxPos   = 32'h7FFF_FFFF;
   localparam logic [ValW-1:0] MinNeg   = 32'h8000_0000;
   localparam logic [ValW-1:0] CacheMax = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CSR_BASE,
      CSR_DECAY,
      CSR_EPS,
      CSR_RHO
   } csr_idx_type;

   typedef struct packed {
      logic             gneg;
      logic             gzero;
      logic [ValW-1:0]  gmag;
      logic [ValW-1:0]  pval;
      logic [G2W-1:0]   g2;
      logic [DmulW-1:0] dmul;
   } front_item_type;

   typedef struct packed {
      logic [ValW-1:0]  cache;
      logic             sat;
      logic             gneg;
      logic             gzero;
      logic [ValW-1:0]  gmag;
      logic [ValW-1:0]  pval;
      logic [DmulW-1:0] dmul;
   } cache_item_type;

endpackage

FILE: src/rpu_fifo.sv
// Short register queue between the front and the back of the update block.
module rpu_fifo #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output logic [W-1:0] head_data
);

   localparam int Depth = rpu_pkg::FifoDepth;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   logic [W-1:0]    buf_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == CntW'(Depth));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = buf_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/rpu_front.sv
// Front stage: takes requests, folds the address, squares the gradient and scales the decay.
module rpu_front #(
   parameter int CACHE_DEPTH = rpu_pkg::CacheDepthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept_en,
   input  logic [rpu_pkg::RateW-1:0]     decay,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rpu_pkg::IdxW-1:0]      req_index,
   input  logic [rpu_pkg::ValW-1:0]      req_grad,
   input  logic [rpu_pkg::ValW-1:0]      req_param,
   input  logic [rpu_pkg::IterW-1:0]     req_iter,
   input  logic                          q_full,
   output logic                          q_push,
   output logic [((CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1)-1:0] q_addr,
   output rpu_pkg::front_item_type       q_item
);

   localparam int AW    = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int IdxW  = rpu_pkg::IdxW;
   localparam int ValW  = rpu_pkg::ValW;
   localparam int IterW = rpu_pkg::IterW;
   localparam int DmulW = rpu_pkg::DmulW;
   localparam int G2W   = rpu_pkg::G2W;

   logic             f_valid_ff, f_valid_in;
   logic [IdxW-1:0]  f_index_ff;
   logic [ValW-1:0]  f_grad_ff, f_param_ff;
   logic [IterW-1:0] f_iter_ff;
   logic             take;
   logic [ValW-1:0]  gmag;
   logic [2*ValW-1:0] gsq;
   logic [DmulW-1:0] dmul;

   // fold an index into the cache range by conditional subtraction
   function automatic logic [AW-1:0] wrap_idx(input logic [IdxW-1:0] x);
      logic [31:0] r;
      r = 32'(x);
      for (int k = IdxW - 1; k >= 0; k--) begin
         if (r >= (32'(CACHE_DEPTH) << k)) begin
            r = r - (32'(CACHE_DEPTH) << k);
         end
      end
      return r[AW-1:0];
   endfunction

   assign req_ready  = accept_en && (!f_valid_ff || !q_full);
   assign take       = req_valid && req_ready;
   assign q_push     = f_valid_ff && !q_full;
   assign f_valid_in = take || (f_valid_ff && !q_push);

   assign gmag = f_grad_ff[ValW-1] ? (~f_grad_ff + 1'b1) : f_grad_ff;
   assign gsq  = gmag * gmag;
   assign dmul = decay * f_iter_ff;

   always_comb begin
      q_addr       = wrap_idx(f_index_ff);
      q_item.gneg  = f_grad_ff[ValW-1];
      q_item.gzero = (f_grad_ff == '0);
      q_item.gmag  = gmag;
      q_item.pval  = f_param_ff;
      q_item.g2    = gsq[rpu_pkg::FracBits +: G2W];
      q_item.dmul  = dmul;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         f_index_ff <= req_index;
         f_grad_ff  <= req_grad;
         f_param_ff <= req_param;
         f_iter_ff  <= req_iter;
      end
   end

endmodule

FILE: src/rpu_cache.sv
// Cache stage: squared-gradient memory, clearing pass and the cache recurrence.
module rpu_cache #(
   parameter int CACHE_DEPTH = rpu_pkg::CacheDepthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [rpu_pkg::RhoW-1:0]      rho,
   input  logic                          head_valid,
   input  logic [((CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1)-1:0] head_addr,
   input  rpu_pkg::front_item_type       head_item,
   output logic                          pop,
   output logic                          clear_done,
   output logic                          out_valid,
   output rpu_pkg::cache_item_type       out_item
);

   localparam int AW       = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int ValW     = rpu_pkg::ValW;
   localparam int RhoW     = rpu_pkg::RhoW;
   localparam int KeepW    = RhoW + ValW;
   localparam int TmulW    = RhoW + rpu_pkg::G2W;
   localparam int ShW      = TmulW + 1 - rpu_pkg::FracBits;
   localparam logic [AW-1:0] LastIdx = AW'(CACHE_DEPTH - 1);

   logic [ValW-1:0] mem [CACHE_DEPTH];
   logic [ValW-1:0] rdata_ff;

   logic [AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic           clr_done_ff, clr_done_in;

   logic           c1_valid_ff, c2_valid_ff, c3_valid_ff;
   logic [AW-1:0]  c1_addr_ff, c2_addr_ff;
   rpu_pkg::front_item_type c1_item_ff, c2_item_ff;
   rpu_pkg::cache_item_type c3_item_ff, c3_item_in;
   logic [KeepW-1:0] keep_ff, keep_in;
   logic [TmulW-1:0] tmul_ff, tmul_in;

   logic [RhoW-1:0]  rho_eff, one_minus;
   logic [TmulW:0]   sum;
   logic [ShW-1:0]   shv;
   logic             cache_sat;
   logic [ValW-1:0]  cache_val;
   logic             hazard;

   assign rho_eff   = (rho > rpu_pkg::OneFix) ? rpu_pkg::OneFix : rho;
   assign one_minus = rpu_pkg::OneFix - rho_eff;
   assign keep_in   = KeepW'(rho_eff) * KeepW'(rdata_ff);
   assign tmul_in   = TmulW'(one_minus) * TmulW'(c1_item_ff.g2);

   assign sum       = (TmulW + 1)'(tmul_ff) + (TmulW + 1)'(keep_ff);
   assign shv       = sum[TmulW:rpu_pkg::FracBits];
   assign cache_sat = |shv[ShW-1:ValW];
   assign cache_val = cache_sat ? rpu_pkg::CacheMax : shv[ValW-1:0];

   // hold an item back while an older one to the same entry has not written yet
   assign hazard = (c1_valid_ff && (c1_addr_ff == head_addr))
                || (c2_valid_ff && (c2_addr_ff == head_addr));
   assign pop    = en && head_valid && clr_done_ff && !hazard;

   assign clr_done_in = clr_done_ff || (clr_cnt_ff == LastIdx);
   assign clr_cnt_in  = clr_done_ff ? clr_cnt_ff : clr_cnt_ff + 1'b1;

   assign clear_done = clr_done_ff;
   assign out_valid  = c3_valid_ff;
   assign out_item   = c3_item_ff;

   always_comb begin
      c3_item_in.cache = cache_val;
      c3_item_in.sat   = cache_sat;
      c3_item_in.gneg  = c2_item_ff.gneg;
      c3_item_in.gzero = c2_item_ff.gzero;
      c3_item_in.gmag  = c2_item_ff.gmag;
      c3_item_in.pval  = c2_item_ff.pval;
      c3_item_in.dmul  = c2_item_ff.dmul;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_done_ff <= 1'b0;
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
         c3_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_done_ff <= clr_done_in;
         if (en) begin
            c1_valid_ff <= pop;
            c2_valid_ff <= c1_valid_ff;
            c3_valid_ff <= c2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_addr_ff <= head_addr;
         c1_item_ff <= head_item;
         c2_addr_ff <= c1_addr_ff;
         c2_item_ff <= c1_item_ff;
         keep_ff    <= keep_in;
         tmul_ff    <= tmul_in;
         c3_item_ff <= c3_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!clr_done_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (en && c2_valid_ff) begin
         mem[c2_addr_ff] <= cache_val;
      end
      if (pop) begin
         rdata_ff <= mem[head_addr];
      end
   end

endmodule

FILE: src/rpu_math.sv
// Back end: pipelined rate divider, square root, step divider, saturating update.
module rpu_math (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [rpu_pkg::RateW-1:0]     base,
   input  logic [rpu_pkg::RateW-1:0]     eps,
   input  logic                          in_valid,
   input  rpu_pkg::cache_item_type       in_item,
   output logic                          out_valid,
   output logic [rpu_pkg::ValW-1:0]      out_param,
   output logic [rpu_pkg::ValW-1:0]      out_cache,
   output logic                          out_sat
);

   localparam int FracBits = rpu_pkg::FracBits;
   localparam int ValW     = rpu_pkg::ValW;
   localparam int RateW    = rpu_pkg::RateW;
   localparam int RadW     = ValW + 1 + FracBits;
   localparam int RootW    = (RadW + 1) / 2;
   localparam int TrialW   = RadW + 1;
   localparam int DenW     = rpu_pkg::DmulW + 1;
   localparam int NumW     = RateW + ValW;
   localparam int WideW    = NumW + 2;

   typedef struct packed {
      logic [ValW-1:0] pval;
      logic [ValW-1:0] cache;
      logic            sat;
      logic            gneg;
      logic            gzero;
   } carry_type;

   typedef struct packed {
      logic [RadW-1:0]  rem;
      logic [RootW-1:0] res;
      logic [DenW-1:0]  lr_r;
      logic [RateW-1:0] lr_q;
      logic [DenW-1:0]  den;
      logic [ValW-1:0]  gmag;
      carry_type        cy;
   } sq_type;

   typedef struct packed {
      logic [RootW-1:0] r;
      logic [NumW-1:0]  nq;
      logic [RootW-1:0] root;
      logic             rz;
      carry_type        cy;
   } dv_type;

   sq_type sq_ff [RootW+1];
   sq_type sq_in [RootW];
   logic   sq_v_ff [RootW+1];
   dv_type dv_ff [NumW+1];
   dv_type dv_in [NumW];
   logic   dv_v_ff [NumW+1];

   sq_type sq0_in;
   dv_type dv0_in;

   logic                 out_valid_ff;
   logic [ValW-1:0]      out_param_ff, out_param_in;
   logic [ValW-1:0]      out_cache_ff;
   logic                 out_sat_ff, out_sat_in;

   logic [WideW-1:0]     pw, sw, npw;
   logic                 ovf;

   // one root bit per stage, plus, in the first RateW stages, one quotient bit of the learning rate
   function automatic sq_type root_step(input sq_type s, input int b, input logic lr_on);
      sq_type            n;
      logic [TrialW-1:0] trial;
      logic [DenW:0]     lsh;
      logic              rge, lge;
      n     = s;
      trial = (TrialW'(s.res) << (b + 1)) + (TrialW'(1) << (2 * b));
      rge   = {1'b0, s.rem} >= trial;
      if (rge) begin
         n.rem = s.rem - trial[RadW-1:0];
         n.res = s.res | (RootW'(1) << b);
      end
      lsh = {s.lr_r, 1'b0};
      lge = lsh >= {1'b0, s.den};
      if (lr_on) begin
         n.lr_q = {s.lr_q[RateW-2:0], lge};
         n.lr_r = lge ? DenW'(lsh - {1'b0, s.den}) : lsh[DenW-1:0];
      end
      return n;
   endfunction

   // one quotient bit of the step per stage
   function automatic dv_type div_step(input dv_type s);
      dv_type        n;
      logic [RootW:0] r2;
      logic          ge;
      n    = s;
      r2   = {s.r, s.nq[NumW-1]};
      ge   = r2 >= {1'b0, s.root};
      n.r  = ge ? RootW'(r2 - {1'b0, s.root}) : r2[RootW-1:0];
      n.nq = {s.nq[NumW-2:0], ge};
      return n;
   endfunction

   always_comb begin
      sq0_in.rem      = {(ValW + 1)'(in_item.cache) + (ValW + 1)'(eps), {FracBits{1'b0}}};
      sq0_in.res      = '0;
      sq0_in.lr_r     = DenW'(base);
      sq0_in.lr_q     = '0;
      sq0_in.den      = DenW'(rpu_pkg::OneFix) + DenW'(in_item.dmul);
      sq0_in.gmag     = in_item.gmag;
      sq0_in.cy.pval  = in_item.pval;
      sq0_in.cy.cache = in_item.cache;
      sq0_in.cy.sat   = in_item.sat;
      sq0_in.cy.gneg  = in_item.gneg;
      sq0_in.cy.gzero = in_item.gzero;
   end

   always_comb begin
      for (int k = 0; k < RootW; k++) begin
         sq_in[k] = root_step(sq_ff[k], RootW - 1 - k, (k < RateW));
      end
   end

   always_comb begin
      dv0_in.r    = '0;
      dv0_in.nq   = NumW'(sq_ff[RootW].lr_q) * NumW'(sq_ff[RootW].gmag);
      dv0_in.root = sq_ff[RootW].res;
      dv0_in.rz   = (sq_ff[RootW].res == '0);
      dv0_in.cy   = sq_ff[RootW].cy;
   end

   always_comb begin
      for (int k = 0; k < NumW; k++) begin
         dv_in[k] = div_step(dv_ff[k]);
      end
   end

   // step against the gradient's sign, clip to signed range; zero root keeps param or saturates
   always_comb begin
      pw  = {{(WideW - ValW){dv_ff[NumW].cy.pval[ValW-1]}}, dv_ff[NumW].cy.pval};
      sw  = {2'b00, dv_ff[NumW].nq};
      npw = dv_ff[NumW].cy.gneg ? pw + sw : pw - sw;
      ovf = (npw[WideW-1:ValW-1] != {(WideW - ValW + 1){npw[WideW-1]}});
      out_sat_in   = dv_ff[NumW].cy.sat;
      out_param_in = npw[ValW-1:0];
      if (dv_ff[NumW].rz) begin
         if (dv_ff[NumW].cy.gzero) begin
            out_param_in = dv_ff[NumW].cy.pval;
         end else begin
            out_param_in = dv_ff[NumW].cy.gneg ? rpu_pkg::MaxPos : rpu_pkg::MinNeg;
            out_sat_in   = 1'b1;
         end
      end else if (ovf) begin
         out_param_in = npw[WideW-1] ? rpu_pkg::MinNeg : rpu_pkg::MaxPos;
         out_sat_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= RootW; k++) begin
            sq_v_ff[k] <= 1'b0;
         end
         for (int k = 0; k <= NumW; k++) begin
            dv_v_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (en) begin
         sq_v_ff[0] <= in_valid;
         for (int k = 0; k < RootW; k++) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
         dv_v_ff[0] <= sq_v_ff[RootW];
         for (int k = 0; k < NumW; k++) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
         out_valid_ff <= dv_v_ff[NumW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= sq0_in;
         for (int k = 0; k < RootW; k++) begin
            sq_ff[k+1] <= sq_in[k];
         end
         dv_ff[0] <= dv0_in;
         for (int k = 0; k < NumW; k++) begin
            dv_ff[k+1] <= dv_in[k];
         end
         out_param_ff <= out_param_in;
         out_cache_ff <= dv_ff[NumW].cy.cache;
         out_sat_ff   <= out_sat_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_param = out_param_ff;
   assign out_cache = out_cache_ff;
   assign out_sat   = out_sat_ff;

endmodule

FILE: src/rmsprop_param_update.sv
// Top level of the RMSProp parameter update block: register port and stream channels.
//
// One request per clock cycle is taken and one result per cycle is returned in steady state,
// while the receiver keeps rsp_tready high and no request waits on a cache hazard; results
// pass through the one-bit-per-stage square-root pipeline (29 stages) and step divider
// (56 stages). A request to a cache entry that an older request in cache stage c1 or c2
// still updates waits, because the second waits for the first one's cache write-back. After
// reset a clearing pass writes zero to every cache entry, during which no request is taken;
// register writes are accepted throughout.
module rmsprop_param_update #(
   parameter int CACHE_DEPTH = rpu_pkg::CacheDepthDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // element_index[11:0], gradient[43:12], param_value[75:44], iteration[95:76]
   input  logic [95:0]                      req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // new_param[31:0], new_cache[63:32]
   output logic [63:0]                      rsp_tdata,
   // saturated[0]
   output logic [0:0]                       rsp_tuser,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rpu_pkg::CsrAddrW-1:0]     csr_paddr,
   input  logic [rpu_pkg::CsrDataW-1:0]     csr_pwdata,
   output logic [rpu_pkg::CsrDataW-1:0]     csr_prdata,
   output logic                             csr_pready
);

   localparam int AW    = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int RateW = rpu_pkg::RateW;
   localparam int RhoW  = rpu_pkg::RhoW;
   localparam int ValW  = rpu_pkg::ValW;
   localparam int DW    = rpu_pkg::CsrDataW;
   localparam int QW    = AW + $bits(rpu_pkg::front_item_type);

   logic [RateW-1:0] base_ff, decay_ff, eps_ff;
   logic [RhoW-1:0]  rho_ff;
   logic             csr_wr;
   rpu_pkg::csr_idx_type csr_idx;

   logic             en;
   logic             clear_done;
   logic             q_full, q_push, q_pop, q_head_valid;
   logic [AW-1:0]    f_addr;
   rpu_pkg::front_item_type f_item, h_item;
   logic [QW-1:0]    q_head;
   logic             c_valid;
   rpu_pkg::cache_item_type c_item;
   logic [ValW-1:0]  new_param, new_cache;
   logic             sat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = rpu_pkg::csr_idx_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_idx)
         rpu_pkg::CSR_BASE:  csr_prdata = DW'(base_ff);
         rpu_pkg::CSR_DECAY: csr_prdata = DW'(decay_ff);
         rpu_pkg::CSR_EPS:   csr_prdata = DW'(eps_ff);
         rpu_pkg::CSR_RHO:   csr_prdata = DW'(rho_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= rpu_pkg::BaseRateRst;
         decay_ff <= rpu_pkg::DecayRst;
         eps_ff   <= rpu_pkg::EpsRst;
         rho_ff   <= rpu_pkg::RhoRst;
      end else if (csr_wr) begin
         unique case (csr_idx)
            rpu_pkg::CSR_BASE:  base_ff  <= csr_pwdata[RateW-1:0];
            rpu_pkg::CSR_DECAY: decay_ff <= csr_pwdata[RateW-1:0];
            rpu_pkg::CSR_EPS:   eps_ff   <= csr_pwdata[RateW-1:0];
            rpu_pkg::CSR_RHO:   rho_ff   <= csr_pwdata[RhoW-1:0];
         endcase
      end
   end

   // advance the back end unless a finished result is still waiting
   assign en = !rsp_tvalid || rsp_tready;

   rpu_front #(
      .CACHE_DEPTH (CACHE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept_en (clear_done),
      .decay     (decay_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_index (req_tdata[11:0]),
      .req_grad  (req_tdata[43:12]),
      .req_param (req_tdata[75:44]),
      .req_iter  (req_tdata[95:76]),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_addr    (f_addr),
      .q_item    (f_item)
   );

   rpu_fifo #(
      .W (QW)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  ({f_addr, f_item}),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head)
   );

   assign h_item = q_head[QW-AW-1:0];

   rpu_cache #(
      .CACHE_DEPTH (CACHE_DEPTH)
   ) u_cache (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .rho        (rho_ff),
      .head_valid (q_head_valid),
      .head_addr  (q_head[QW-1:QW-AW]),
      .head_item  (h_item),
      .pop        (q_pop),
      .clear_done (clear_done),
      .out_valid  (c_valid),
      .out_item   (c_item)
   );

   rpu_math u_math (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .base      (base_ff),
      .eps       (eps_ff),
      .in_valid  (c_valid),
      .in_item   (c_item),
      .out_valid (rsp_tvalid),
      .out_param (new_param),
      .out_cache (new_cache),
      .out_sat   (sat)
   );

   assign rsp_tdata = {new_cache, new_param};
   assign rsp_tuser = sat;

endmodule

FILE: test/rpu_checker.sv
// Checker for the RMSProp update block: predicts each result and compares it.
module rpu_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [95:0]                  req_tdata,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [63:0]                  rsp_tdata,
   input  logic [0:0]                   rsp_tuser,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [rpu_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [rpu_pkg::CsrDataW-1:0] csr_pwdata,
   input  logic                         csr_pready,
   output int                           fail_count,
   output int                           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0] param;
      logic [31:0] cache;
      logic        sat;
   } update_type;

   logic [23:0]  lr_base;
   logic [23:0]  lr_decay;
   logic [23:0]  eps;
   logic [24:0]  rho_reg;
   logic [31:0]  sq_cache [rpu_pkg::CacheDepthDefault];
   update_type   expected_updates [$];

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Update cache and predict the result for one request.
   function automatic update_type predict_update(logic [95:0] d);
      logic [11:0]          addr;
      logic signed [31:0]   g;
      logic signed [31:0]   p;
      logic [19:0]          iter;
      logic [24:0]          rho;
      logic [63:0]          gmag;
      logic [63:0]          g2;
      logic [127:0]         acc;
      logic [127:0]         cnew;
      logic [63:0]          lr;
      logic [63:0]          root;
      logic [127:0]         stepv;
      logic signed [65:0]   np;
      update_type           u;
      addr = d[11:0];
      g = d[43:12];
      p = d[75:44];
      iter = d[95:76];
      u.sat = 0;
      rho = (rho_reg > rpu_pkg::OneFix) ? rpu_pkg::OneFix : rho_reg;
      gmag = g < 0 ? 64'(-66'(g)) : 64'(g);
      g2 = (gmag * gmag) >> rpu_pkg::FracBits;
      acc = 128'(g2) * 128'(rpu_pkg::OneFix - rho) + 128'(rho) * 128'(sq_cache[addr]);
      cnew = acc >> rpu_pkg::FracBits;
      if (cnew > 128'hFFFF_FFFF) begin
         u.cache = rpu_pkg::CacheMax;
         u.sat = 1;
      end else begin
         u.cache = cnew[31:0];
      end
      sq_cache[addr] = u.cache;
      lr = 64'(lr_base);
      if (lr_decay != 0)
         lr = (64'(lr_base) << rpu_pkg::FracBits)
              / (64'(rpu_pkg::OneFix) + 64'(lr_decay) * 64'(iter));
      root = int_sqrt((64'(u.cache) + 64'(eps)) << rpu_pkg::FracBits);
      if (root == 0) begin
         if (g == 0) begin
            u.param = p;
         end else begin
            u.param = g > 0 ? rpu_pkg::MinNeg : rpu_pkg::MaxPos;
            u.sat = 1;
         end
      end else begin
         stepv = (128'(lr) * 128'(gmag)) / 128'(root);
         np = g < 0 ? 66'(p) + 66'(stepv[63:0]) : 66'(p) - 66'(stepv[63:0]);
         if (np > 66'sd2147483647) begin
            u.param = rpu_pkg::MaxPos;
            u.sat = 1;
         end else if (np < -66'sd2147483648) begin
            u.param = rpu_pkg::MinNeg;
            u.sat = 1;
         end else begin
            u.param = np[31:0];
         end
      end
      return u;
   endfunction

   assign pending_count = expected_updates.size();

   always @(posedge clock) begin
      update_type e;
      int         errs;
      errs = 0;
      if (reset) begin
         lr_base <= rpu_pkg::BaseRateRst;
         lr_decay <= rpu_pkg::DecayRst;
         eps <= rpu_pkg::EpsRst;
         rho_reg <= rpu_pkg::RhoRst;
         for (int i = 0; i < rpu_pkg::CacheDepthDefault; i++) sq_cache[i] = 0;
         expected_updates.delete();
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (rpu_pkg::csr_idx_type'(csr_paddr[3:2]))
               rpu_pkg::CSR_BASE:  lr_base <= csr_pwdata[23:0];
               rpu_pkg::CSR_DECAY: lr_decay <= csr_pwdata[23:0];
               rpu_pkg::CSR_EPS:   eps <= csr_pwdata[23:0];
               rpu_pkg::CSR_RHO:   rho_reg <= csr_pwdata[24:0];
            endcase
         end
         if (req_tvalid && req_tready)
            expected_updates.push_back(predict_update(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_updates.size() == 0) begin
               $error("result with no request outstanding");
               errs++;
            end else begin
               e = expected_updates.pop_front();
               if (rsp_tdata[31:0] !== e.param) begin
                  $error("new_param expected %h actual %h", e.param, rsp_tdata[31:0]);
                  errs++;
               end
               if (rsp_tdata[63:32] !== e.cache) begin
                  $error("new_cache expected %h actual %h", e.cache, rsp_tdata[63:32]);
                  errs++;
               end
               if (rsp_tuser[0] !== e.sat) begin
                  $error("saturated expected %b actual %b", e.sat, rsp_tuser[0]);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule

FILE: test/tb.sv
// Testbench top for the RMSProp update block: stimulus, register phases and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                         clock = 0;
   logic                         reset = 1;
   logic                         req_tvalid = 0;
   logic                         req_tready;
   logic [95:0]                  req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 0;
   logic [63:0]                  rsp_tdata;
   logic [0:0]                   rsp_tuser;
   logic                         csr_psel = 0;
   logic                         csr_penable = 0;
   logic                         csr_pwrite = 0;
   logic [rpu_pkg::CsrAddrW-1:0] csr_paddr = '0;
   logic [rpu_pkg::CsrDataW-1:0] csr_pwdata = '0;
   logic [rpu_pkg::CsrDataW-1:0] csr_prdata;
   logic                         csr_pready;
   int                           fail_count;
   int                           pending_count;
   logic                         stall_free;

   rmsprop_param_update dut (.*);
   rpu_checker checker_i (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Receiver stalls on its own pattern; some stretches never stall.
   always @(posedge clock) begin
      if (stall_free) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   initial begin
      #40ms;
      $display("rmsprop_param_update verification failed");
      $finish;
   end

   task automatic write_reg(rpu_pkg::csr_idx_type idx, logic [31:0] value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= rpu_pkg::CsrAddrW'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   // Present one request and hold it until accepted.
   task automatic send_update(logic [11:0] idx, logic [31:0] g, logic [31:0] p,
                              logic [19:0] iter);
      req_tvalid <= 1;
      req_tdata <= {iter, p, g, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic idle_gap(int n);
      req_tvalid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_grad();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
         2: return 32'($signed($urandom_range(0, 1 << 28)) - (1 << 27));
         3: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
         default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      endcase
   endfunction

   task automatic random_phase(int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < count; i++) begin
            // Hit a few hot entries often so back-to-back cache reuse is exercised.
            send_update($urandom_range(0, 1) ? 12'($urandom_range(0, 7)) : 12'($urandom),
                        rand_grad(), $urandom, 20'($urandom));
            sent++;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
         if (sent > count / 2 && sent - burst <= count / 2) drain();
      end
      drain();
   endtask

   initial begin
      stall_free = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      // Directed: field extremes, zero root cases, overflow, address extremes.
      write_reg(rpu_pkg::CSR_EPS, 0);
      send_update(12'd5, 32'd0, 32'h1234_5678, 20'd0);
      send_update(12'd6, 32'd1, 32'h0000_0100, 20'd0);
      send_update(12'd7, 32'hFFFF_FFFF, 32'h0000_0100, 20'd0);
      drain();
      write_reg(rpu_pkg::CSR_EPS, 24'hFF_FFFF);
      write_reg(rpu_pkg::CSR_BASE, 24'hFF_FFFF);
      send_update(12'd0, 32'h8000_0000, 32'h7FFF_FFFF, 20'hF_FFFF);
      send_update(12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000, 20'd0);
      send_update(12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000, 20'd0);
      send_update(12'd0, 32'h8000_0000, 32'h7FFF_FFFF, 20'd0);
      send_update(12'd1, 32'h0100_0000, 32'h0, 20'd1);
      drain();
      write_reg(rpu_pkg::CSR_RHO, 25'h1FF_FFFF);
      write_reg(rpu_pkg::CSR_DECAY, 24'hFF_FFFF);
      send_update(12'hFFF, 32'h7FFF_FFFF, 32'd0, 20'hF_FFFF);
      send_update(12'd1, 32'hFF00_0000, 32'd0, 20'd1);
      drain();
      write_reg(rpu_pkg::CSR_RHO, 0);
      send_update(12'd2, 32'h7FFF_FFFF, 32'd0, 20'd3);
      send_update(12'd2, 32'h7FFF_FFFF, 32'd0, 20'd3);
      drain();
      // Random phases across register settings.
      for (int ph = 0; ph < 5; ph++) begin
         stall_free = (ph == 2);
         write_reg(rpu_pkg::CSR_BASE, ph == 0 ? 0 : $urandom_range(0, 24'hFF_FFFF));
         write_reg(rpu_pkg::CSR_DECAY, ph < 2 ? 0 : $urandom_range(0, 24'hFF_FFFF));
         write_reg(rpu_pkg::CSR_EPS, ph == 4 ? 24'hFF_FFFF : $urandom_range(0, 255));
         write_reg(rpu_pkg::CSR_RHO,
                   ph == 3 ? rpu_pkg::OneFix : $urandom_range(0, 25'h100_0000));
         random_phase(200);
      end
      if (fail_count == 0) begin
         $display("rmsprop_param_update verification clean");
      end else begin
         $display("rmsprop_param_update verification failed");
      end
      $finish;
   end
endmodule
